// File: sv/tbdc_pkg.sv
// Shared types, codes and reset values for the two-button debounce and chord block.
// No dependencies; imported by every module of the block.
package tbdc_pkg;

	localparam int AGE_W   = 8;
	localparam int BOTH_W  = 16;
	localparam int CFG_W   = 16;

	localparam logic [AGE_W-1:0]  AGE_MAX  = {AGE_W{1'b1}};
	localparam logic [BOTH_W-1:0] BOTH_MAX = {BOTH_W{1'b1}};

	localparam logic [AGE_W-1:0]  DEBOUNCE_RST = 8'd6;
	localparam logic [BOTH_W-1:0] CHORD_RST    = 16'd600;
	localparam logic [BOTH_W-1:0] SETUP_RST    = 16'd2000;

	typedef enum logic [1:0] {
		CFG_DEBOUNCE = 2'd0,
		CFG_CHORD    = 2'd1,
		CFG_SETUP    = 2'd2,
		CFG_MODE     = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		SW_NONE = 2'd0,
		SW_PREV = 2'd1,
		SW_NEXT = 2'd2
	} switch_req_t;

	// Per-button status for the tick being processed, before any resync
	typedef struct packed {
		logic click;
		logic release_evt;
		logic down_pre;   // debounced pressed before any resync
	} btn_stat_t;

	// Events from the chord logic
	typedef struct packed {
		switch_req_t sw;
		logic        net;
		logic        leave;
		logic        enter;
		logic        resync;
	} chord_evt_t;

endpackage

// File: sv/tbdc_debounce.sv
// Debounce for one button: previous sample, level age and accepted level.
// Depends on tbdc_pkg.
module tbdc_debounce (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      step,
	input  logic                      raw,
	input  logic                      resync,
	input  logic [tbdc_pkg::AGE_W-1:0] debounce_ticks,
	output tbdc_pkg::btn_stat_t       stat,
	output logic                      down
);
	import tbdc_pkg::*;

	logic             prev_q, acc_q;
	logic [AGE_W-1:0] age_q;
	logic             prev_t, acc_t;
	logic [AGE_W-1:0] age_t, age_inc;
	logic             prev_n, acc_n;
	logic [AGE_W-1:0] age_n;

	always_comb begin
		age_inc = (age_q != AGE_MAX) ? age_q + 1'b1 : age_q;
		prev_t = prev_q;
		acc_t  = acc_q;
		age_t  = age_q;
		stat   = '0;
		if (raw != prev_q) begin
			prev_t = raw;
			age_t  = '0;
		end else begin
			age_t = age_inc;
			if (raw != acc_q && age_inc >= debounce_ticks) begin
				acc_t = raw;
				stat.click       = !raw;
				stat.release_evt = raw;
			end
		end
		stat.down_pre = !acc_t;
	end

	// resync: take the current sample as settled
	always_comb begin
		prev_n = resync ? raw : prev_t;
		acc_n  = resync ? raw : acc_t;
		age_n  = resync ? '0 : age_t;
		down   = !acc_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= 1'b1;
			acc_q  <= 1'b1;
			age_q  <= '0;
		end else if (step) begin
			prev_q <= prev_n;
			acc_q  <= acc_n;
			age_q  <= age_n;
		end
	end

endmodule

// File: sv/tbdc_chord.sv
// Two-button session tracking: chord timing, setup entry/exit, switch requests.
// Depends on tbdc_pkg.
module tbdc_chord (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  tbdc_pkg::btn_stat_t         left,
	input  tbdc_pkg::btn_stat_t         right,
	input  logic                        in_setup,
	input  logic [tbdc_pkg::BOTH_W-1:0] chord_ticks,
	input  logic [tbdc_pkg::BOTH_W-1:0] setup_ticks,
	output tbdc_pkg::chord_evt_t        evt
);
	import tbdc_pkg::*;

	logic              seen_q, chord_q, setup_q, armed_q;
	logic [BOTH_W-1:0] both_age_q;
	logic              seen_n, chord_n, setup_n, armed_n;
	logic [BOTH_W-1:0] both_age_n;
	logic              armed_now, both_down, none_down;

	always_comb begin
		armed_now  = armed_q || !in_setup;
		both_down  = left.down_pre && right.down_pre;
		none_down  = !left.down_pre && !right.down_pre;
		seen_n     = seen_q;
		chord_n    = chord_q;
		setup_n    = setup_q;
		armed_n    = armed_q;
		both_age_n = (seen_q && both_age_q != BOTH_MAX) ? both_age_q + 1'b1 : both_age_q;
		evt        = '0;
		evt.sw     = SW_NONE;

		if (both_down) begin
			if (!seen_q) begin
				seen_n     = 1'b1;
				both_age_n = '0;
			end else if (!chord_q && armed_now && both_age_n >= chord_ticks) begin
				chord_n = 1'b1;
				evt.leave = in_setup;
				evt.net   = !in_setup;
			end else if (!setup_q && !in_setup && both_age_n >= setup_ticks) begin
				setup_n   = 1'b1;
				evt.enter = 1'b1;
			end
		end

		// single release switches disks; right wins a tie
		if ((left.release_evt || right.release_evt) && !seen_n && !in_setup) begin
			evt.sw     = right.release_evt ? SW_NEXT : SW_PREV;
			evt.resync = 1'b1;
		end

		// session end uses levels before resync
		if (none_down) begin
			seen_n  = 1'b0;
			chord_n = 1'b0;
			armed_n = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q     <= 1'b0;
			chord_q    <= 1'b0;
			setup_q    <= 1'b0;
			armed_q    <= 1'b0;
			both_age_q <= '0;
		end else if (step) begin
			seen_q     <= seen_n;
			chord_q    <= chord_n;
			setup_q    <= setup_n;
			armed_q    <= armed_n;
			both_age_q <= both_age_n;
		end
	end

endmodule

// File: sv/two_button_debounce_chord.sv
// Top level of the two-button debounce and chord block: input register,
// config registers, per-button debounce, chord logic and result register.
// Depends on tbdc_pkg, tbdc_debounce and tbdc_chord.
//
// Usage:
//   Input channel (in_valid/in_ready, raw_left, raw_right): one transaction is
//   one poll tick carrying raw active-low button levels.
//   Output channel (out_valid/out_ready): one result transaction per input
//   transaction, in order: clicks, switch request, chord events, debounced
//   levels.
//   Config port (cfg_we, cfg_index, cfg_data): write only while idle.
//   Path: a tick accepted into the input register has its result loaded into
//   the output register when the input register advances, which waits while
//   a stalled result is held.
//   Throughput: one tick per cycle while results are not stalled; the button
//   state updates when the input register hands its tick to the output
//   register, so every tick sees the state left by the one before.
//   Stall: while out_ready is low the result is held; the input register still
//   takes one more transaction, then in_ready drops until the result moves.
//   Reset: both buttons assumed released, all counters and session flags
//   cleared, registers at their defaults (6, 600, 2000, normal mode).
module two_button_debounce_chord (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        raw_left,
	input  logic                        raw_right,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        click_left,
	output logic                        click_right,
	output logic [1:0]                  switch_request,
	output logic                        show_network,
	output logic                        leave_setup,
	output logic                        enter_setup,
	output logic                        left_down,
	output logic                        right_down,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [tbdc_pkg::CFG_W-1:0]  cfg_data
);
	import tbdc_pkg::*;

	// config registers
	logic [AGE_W-1:0]  debounce_q;
	logic [BOTH_W-1:0] chord_ticks_q;
	logic [BOTH_W-1:0] setup_ticks_q;
	logic              setup_on_q;

	// input stage
	logic valid_s1, raw_left_s1, raw_right_s1;
	logic advance;

	btn_stat_t  left_stat, right_stat;
	logic       left_down_n, right_down_n;
	chord_evt_t evt;

	// advance the input stage when the output register is free or draining
	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q    <= DEBOUNCE_RST;
			chord_ticks_q <= CHORD_RST;
			setup_ticks_q <= SETUP_RST;
			setup_on_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_DEBOUNCE: debounce_q    <= cfg_data[AGE_W-1:0];
				CFG_CHORD:    chord_ticks_q <= cfg_data[BOTH_W-1:0];
				CFG_SETUP:    setup_ticks_q <= cfg_data[BOTH_W-1:0];
				CFG_MODE:     setup_on_q    <= cfg_data[0];
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload: hold unless a new transaction arrives
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			raw_left_s1  <= raw_left;
			raw_right_s1 <= raw_right;
		end
	end

	tbdc_debounce u_left (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (advance),
		.raw            (raw_left_s1),
		.resync         (evt.resync),
		.debounce_ticks (debounce_q),
		.stat           (left_stat),
		.down           (left_down_n)
	);

	tbdc_debounce u_right (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (advance),
		.raw            (raw_right_s1),
		.resync         (evt.resync),
		.debounce_ticks (debounce_q),
		.stat           (right_stat),
		.down           (right_down_n)
	);

	tbdc_chord u_chord (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.left        (left_stat),
		.right       (right_stat),
		.in_setup    (setup_on_q),
		.chord_ticks (chord_ticks_q),
		.setup_ticks (setup_ticks_q),
		.evt         (evt)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			click_left     <= left_stat.click;
			click_right    <= right_stat.click;
			switch_request <= evt.sw;
			show_network   <= evt.net;
			leave_setup    <= evt.leave;
			enter_setup    <= evt.enter;
			left_down      <= left_down_n;
			right_down     <= right_down_n;
		end
	end

	// input stage only blocks when it holds a tick behind a stalled result
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid && !out_ready))
		else $error("in_ready low without a stalled result");

	// a switch request never comes out of a chord session
	a_sw_no_chord: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && switch_request != SW_NONE) |->
		(!show_network && !leave_setup && !enter_setup))
		else $error("switch request with chord event");

	// a left click leaves the left button down
	a_click_down: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && click_left) |-> left_down)
		else $error("left click without left down");

	// show_network and leave_setup are exclusive per tick
	a_net_leave: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(show_network && leave_setup))
		else $error("show_network and leave_setup together");

	a_sw_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (switch_request == SW_NONE || switch_request == SW_PREV ||
		               switch_request == SW_NEXT))
		else $error("invalid switch request code");

endmodule

// File: verif/chord_event_checker.sv
// Checker for two_button_debounce_chord: watches the config port and both channels,
// predicts each tick result and compares it with what the block returns.
// Depends on tbdc_pkg for widths, reset values, register indexes and switch codes.
`timescale 1ns / 100ps

module chord_event_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  logic                       raw_left,
	input  logic                       raw_right,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  logic                       click_left,
	input  logic                       click_right,
	input  logic [1:0]                 switch_request,
	input  logic                       show_network,
	input  logic                       leave_setup,
	input  logic                       enter_setup,
	input  logic                       left_down,
	input  logic                       right_down,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [tbdc_pkg::CFG_W-1:0] cfg_data,
	output int                         fail_count
);
	import tbdc_pkg::*;

	typedef struct packed {
		logic        click_l;
		logic        click_r;
		switch_req_t sw;
		logic        net;
		logic        leave;
		logic        enter;
		logic        l_down;
		logic        r_down;
	} tick_result_t;

	// Settings as last written
	logic [AGE_W-1:0]  deb_ticks;
	logic [BOTH_W-1:0] chord_lim;
	logic [BOTH_W-1:0] setup_lim;
	logic              setup_on;

	// Button and session state, index 0 is left
	logic [1:0]        stable_lvl;
	logic [1:0]        prior_raw;
	logic [AGE_W-1:0]  hold_age [2];
	logic              in_session;
	logic              chord_sent;
	logic              setup_sent;
	logic              armed;
	logic [BOTH_W-1:0] pair_age;

	tick_result_t expected_events [$];
	int errs = 0;

	assign fail_count = errs;

	task automatic clear_state();
		deb_ticks   = DEBOUNCE_RST;
		chord_lim   = CHORD_RST;
		setup_lim   = SETUP_RST;
		setup_on    = 1'b0;
		stable_lvl  = 2'b11;
		prior_raw   = 2'b11;
		hold_age[0] = '0;
		hold_age[1] = '0;
		in_session  = 1'b0;
		chord_sent  = 1'b0;
		setup_sent  = 1'b0;
		armed       = 1'b0;
		pair_age    = '0;
		expected_events.delete();
	endtask

	task automatic predict_tick(input logic rl, input logic rr);
		logic [1:0]   raw;
		logic [1:0]   click;
		int           released;
		logic         d0, d1, armed_now;
		tick_result_t r;
		raw      = {rr, rl};
		click    = 2'b00;
		released = -1;
		for (int i = 0; i < 2; i++) begin
			if (raw[i] != prior_raw[i]) begin
				prior_raw[i] = raw[i];
				hold_age[i] = '0;
			end else begin
				if (hold_age[i] != AGE_MAX)
					hold_age[i]++;
				if (raw[i] != stable_lvl[i] && hold_age[i] >= deb_ticks) begin
					stable_lvl[i] = raw[i];
					if (!raw[i])
						click[i] = 1'b1;
					else
						released = i;
				end
			end
		end

		d0        = !stable_lvl[0];
		d1        = !stable_lvl[1];
		armed_now = armed || !setup_on;
		r         = '0;
		r.sw      = SW_NONE;

		if (in_session && pair_age != BOTH_MAX)
			pair_age++;

		if (d0 && d1) begin
			if (!in_session) begin
				in_session = 1'b1;
				pair_age   = '0;
			end else if (!chord_sent && armed_now && pair_age >= chord_lim) begin
				chord_sent = 1'b1;
				if (setup_on)
					r.leave = 1'b1;
				else
					r.net = 1'b1;
			end else if (!setup_sent && !setup_on && pair_age >= setup_lim) begin
				setup_sent = 1'b1;
				r.enter    = 1'b1;
			end
		end

		// Resync both buttons to the current sample after a switch
		if (released >= 0 && !in_session && !setup_on) begin
			r.sw        = (released == 0) ? SW_PREV : SW_NEXT;
			stable_lvl  = raw;
			prior_raw   = raw;
			hold_age[0] = '0;
			hold_age[1] = '0;
		end

		if (!d0 && !d1) begin
			in_session = 1'b0;
			chord_sent = 1'b0;
			armed      = 1'b1;
		end

		r.click_l = click[0];
		r.click_r = click[1];
		r.l_down  = !stable_lvl[0];
		r.r_down  = !stable_lvl[1];
		expected_events.push_back(r);
	endtask

	always @(posedge clk) begin
		tick_result_t want;
		logic         bad;
		if (!arst_n) begin
			clear_state();
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_DEBOUNCE: deb_ticks = cfg_data[AGE_W-1:0];
					CFG_CHORD:    chord_lim = cfg_data[BOTH_W-1:0];
					CFG_SETUP:    setup_lim = cfg_data[BOTH_W-1:0];
					CFG_MODE:     setup_on  = cfg_data[0];
					default:      ;
				endcase
			end

			if (in_valid && in_ready)
				predict_tick(raw_left, raw_right);

			if (out_valid && out_ready) begin
				if (expected_events.size() == 0) begin
					errs++;
					if (errs <= 10)
						$display("%0t: result with nothing pending", $realtime);
				end else begin
					want = expected_events.pop_front();
					bad  = (want.click_l !== click_left) || (want.click_r !== click_right)
						|| (want.sw !== switch_request) || (want.net !== show_network)
						|| (want.leave !== leave_setup) || (want.enter !== enter_setup)
						|| (want.l_down !== left_down) || (want.r_down !== right_down);
					if (bad) begin
						errs++;
						if (errs <= 10)
							$display({"%0t: mismatch want click %b%b sw %0d net %b leave %b ",
								"enter %b down %b%b, got click %b%b sw %0d net %b leave %b ",
								"enter %b down %b%b"}, $realtime,
								want.click_l, want.click_r, want.sw, want.net, want.leave,
								want.enter, want.l_down, want.r_down,
								click_left, click_right, switch_request, show_network,
								leave_setup, enter_setup, left_down, right_down);
					end
				end
			end
		end
	end

endmodule

// File: verif/two_button_debounce_chord_test.sv
// Top of the two_button_debounce_chord testbench: clock, reset, config writes,
// tick stimulus with random backpressure, and the verdict.
// Depends on tbdc_pkg, two_button_debounce_chord and chord_event_checker.
`timescale 1ns / 100ps

module two_button_debounce_chord_test;
	import tbdc_pkg::*;

	localparam int LIMIT_CYCLES = 200000;

	logic                clk;
	logic                arst_n         = 1'b0;
	logic                in_valid       = 1'b0;
	logic                in_ready;
	logic                raw_left       = 1'b1;
	logic                raw_right      = 1'b1;
	logic                out_valid;
	logic                out_ready      = 1'b0;
	logic                click_left;
	logic                click_right;
	logic [1:0]          switch_request;
	logic                show_network;
	logic                leave_setup;
	logic                enter_setup;
	logic                left_down;
	logic                right_down;
	logic                cfg_we         = 1'b0;
	logic [1:0]          cfg_index      = CFG_DEBOUNCE;
	logic [CFG_W-1:0]    cfg_data       = '0;
	int                  fail_count;

	int ticks_sent    = 0;   // input transactions accepted
	int ticks_back    = 0;   // result transactions accepted
	int gap_pct       = 35;  // chance in percent of an idle cycle on the input side
	int stall_pct     = 35;  // chance in percent of out_ready low
	int cycle_count   = 0;

	// 12 ns period
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	two_button_debounce_chord dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.raw_left       (raw_left),
		.raw_right      (raw_right),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.click_left     (click_left),
		.click_right    (click_right),
		.switch_request (switch_request),
		.show_network   (show_network),
		.leave_setup    (leave_setup),
		.enter_setup    (enter_setup),
		.left_down      (left_down),
		.right_down     (right_down),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	chord_event_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.raw_left       (raw_left),
		.raw_right      (raw_right),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.click_left     (click_left),
		.click_right    (click_right),
		.switch_request (switch_request),
		.show_network   (show_network),
		.leave_setup    (leave_setup),
		.enter_setup    (enter_setup),
		.left_down      (left_down),
		.right_down     (right_down),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.fail_count     (fail_count)
	);

	// Drop out_ready at random on the falling edge; hold it high when stalls are off
	always @(negedge clk) begin
		out_ready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
	end

	// Count result transactions so the stimulus knows when the block is drained
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			ticks_back <= ticks_back + 1;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Offer one poll tick; return on the falling edge after it is taken.
	// Leave in_valid high on return so back-to-back ticks need no second
	// assignment in the same time step.
	task automatic send_tick(input logic l, input logic r);
		while (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		raw_left  <= l;
		raw_right <= r;
		do
			@(posedge clk);
		while (!in_ready);
		ticks_sent++;
		@(negedge clk);
	endtask

	task automatic hold_levels(input logic l, input logic r, input int n);
		repeat (n)
			send_tick(l, r);
	endtask

	// Drop valid and wait for every pending result: the block is idle after that,
	// since every tick returns exactly one result
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (ticks_back != ticks_sent)
			@(negedge clk);
	endtask

	// Write all four registers on consecutive cycles, then drop the write enable
	task automatic load_settings(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] chord,
		input logic [CFG_W-1:0] setup, input logic [CFG_W-1:0] mode);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_DEBOUNCE;
		cfg_data  <= deb;
		@(negedge clk);
		cfg_index <= CFG_CHORD;
		cfg_data  <= chord;
		@(negedge clk);
		cfg_index <= CFG_SETUP;
		cfg_data  <= setup;
		@(negedge clk);
		cfg_index <= CFG_MODE;
		cfg_data  <= mode;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Random button activity: hold a level pair long enough to pass debounce most
	// of the time, sometimes only a glitch, with a little per-tick noise on top.
	task automatic press_sequences(input int n_ticks, input int deb, input int hold_max);
		int         done;
		int         len;
		logic [1:0] pat;
		logic [1:0] noisy;
		done = 0;
		while (done < n_ticks) begin
			pat = 2'($urandom_range(0, 3));
			if ($urandom_range(0, 4) == 0)
				len = $urandom_range(1, deb);
			else
				len = $urandom_range(deb + 1, deb + 1 + hold_max);
			for (int k = 0; k < len && done < n_ticks; k++) begin
				noisy = pat;
				if ($urandom_range(0, 99) < 4)
					noisy = pat ^ 2'($urandom_range(1, 3));
				send_tick(noisy[1], noisy[0]);
				done++;
			end
		end
	endtask

	initial begin
		// Hold reset, then release it on a falling edge
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: debounce of one (upper bits of the data are dropped), short chord
		load_settings(16'hAB01, 16'd3, 16'd5, 16'd0);
		hold_levels(1'b1, 1'b1, 1);
		hold_levels(1'b0, 1'b1, 3);   // left press, click
		hold_levels(1'b1, 1'b1, 2);   // left release, previous disk
		hold_levels(1'b1, 1'b0, 2);   // right press, click
		hold_levels(1'b1, 1'b1, 2);   // right release, next disk
		hold_levels(1'b0, 1'b0, 9);   // both: clicks, chord, then setup entry
		hold_levels(1'b1, 1'b1, 3);   // release after a chord: no switch
		hold_levels(1'b0, 1'b1, 1);   // glitch, rejected
		hold_levels(1'b1, 1'b1, 1);
		drain();

		// Normal mode, moderate timing
		load_settings(16'd2, 16'd8, 16'd14, 16'd0);
		press_sequences(100, 2, 30);
		drain();

		// Setup mode at the low extremes: leave-setup, no switches
		load_settings(16'd1, 16'd1, 16'd1, 16'd1);
		press_sequences(90, 1, 8);
		drain();

		// Normal mode with chord and setup limits met together
		load_settings(16'd1, 16'd1, 16'd1, 16'd0);
		press_sequences(50, 1, 8);
		drain();

		// High extremes, no idling on either side; mode bit 0 with upper bits set
		gap_pct   = 0;
		stall_pct = 0;
		load_settings(16'd3, 16'hFFFF, 16'hFFFF, 16'hFFFE);
		press_sequences(70, 3, 20);
		drain();
		gap_pct   = 35;
		stall_pct = 35;

		// Setup mode with reset-like debounce
		load_settings(16'd6, 16'd20, 16'd40, 16'd1);
		press_sequences(90, 6, 60);
		drain();

		// Longest debounce: only very long holds are accepted
		load_settings(16'd255, 16'd300, 16'd600, 16'd0);
		hold_levels(1'b0, 1'b1, 260);
		hold_levels(1'b1, 1'b1, 260);
		hold_levels(1'b0, 1'b0, 3);
		hold_levels(1'b1, 1'b1, 5);
		drain();

		// Let any stray result surface before the verdict
		repeat (8) @(negedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// File: two_button_debounce_chord.f
sv/tbdc_pkg.sv
sv/tbdc_debounce.sv
sv/tbdc_chord.sv
sv/two_button_debounce_chord.sv
verif/chord_event_checker.sv
verif/two_button_debounce_chord_test.sv
